// ===== rtl/dlsd_pkg.sv =====
package dlsd_pkg;

	localparam int WL_W       = 6;
	localparam int THR_W      = 10;
	localparam int RECAL_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELTA_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECAL_INTERVAL  = 2'd2;

	localparam logic [WL_W-1:0]    WINDOW_LENGTH_RST   = 6'd8;
	localparam logic [THR_W-1:0]   DELTA_THRESHOLD_RST = 10'd50;
	localparam logic [RECAL_W-1:0] RECAL_INTERVAL_RST  = 16'd100;

	typedef struct packed {
		logic add;
		logic start;
		logic step;
		logic clear;
	} lane_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} ctrl_state_t;

endpackage

// ===== rtl/dual_line_sensor_detector.sv =====
// channel  | handshake                    | payload
// sample   | sample_valid / sample_ready  | left_sample, right_sample
// result   | result_valid / result_ready  | left_average, right_average, flags
// config   | cfg_wr_en                    | cfg_index, cfg_wr_data
//
// a request that does not close a window is taken and leaves the sample side open
// a request that closes a window runs the serial divider of each lane at one
// quotient bit per cycle, then the merge
// arst_n clears sums, counts, baselines and config registers to their reset values
// a waiting result holds the next measurement window end, and with it the sample side
module dual_line_sensor_detector import dlsd_pkg::*; #(
	parameter int MAX_WINDOW  = 32,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [SAMPLE_BITS-1:0] left_sample,
	input  logic [SAMPLE_BITS-1:0] right_sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [SAMPLE_BITS-1:0] left_average,
	output logic [SAMPLE_BITS-1:0] right_average,
	output logic                   left_on_black,
	output logic                   right_on_black
);

	localparam int IDX_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + IDX_W;
	localparam int STEP_W = $clog2(SUM_W);
	localparam int WLX_W  = WL_W + 1;

	logic [WL_W-1:0]    window_length_q;
	logic [THR_W-1:0]   delta_threshold_q;
	logic [RECAL_W-1:0] recal_interval_q;

	ctrl_state_t        state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [STEP_W-1:0]  step_q;
	logic [WLX_W-1:0]   wl_ext;
	logic [WLX_W-1:0]   len_ext;
	logic [IDX_W-1:0]   len;
	logic [IDX_W-1:0]   idx_next;
	logic               accept;
	logic               last;
	logic               can_take;
	logic               load;
	lane_ctrl_t         lane_ctrl;
	logic [SAMPLE_BITS-1:0] avg_left;
	logic [SAMPLE_BITS-1:0] avg_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q   <= WINDOW_LENGTH_RST;
			delta_threshold_q <= DELTA_THRESHOLD_RST;
			recal_interval_q  <= RECAL_INTERVAL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH:   window_length_q   <= cfg_wr_data[WL_W-1:0];
				REG_DELTA_THRESHOLD: delta_threshold_q <= cfg_wr_data[THR_W-1:0];
				REG_RECAL_INTERVAL:  recal_interval_q  <= cfg_wr_data[RECAL_W-1:0];
				default: ;
			endcase
		end
	end

	// zero counts as one, anything above the maximum saturates
	assign wl_ext = {1'b0, window_length_q};
	always_comb begin
		priority if (wl_ext == '0) begin
			len_ext = WLX_W'(1);
		end else if (wl_ext > WLX_W'(MAX_WINDOW)) begin
			len_ext = WLX_W'(MAX_WINDOW);
		end else begin
			len_ext = wl_ext;
		end
	end
	assign len = len_ext[IDX_W-1:0];

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign idx_next     = idx_q + 1'b1;
	assign last         = (idx_next >= len);
	assign load         = (state_q == ST_DONE) && can_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last) begin
							idx_q   <= '0;
							step_q  <= '0;
							state_q <= ST_DIV;
						end else begin
							idx_q <= idx_next;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (can_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign lane_ctrl.add   = accept;
	assign lane_ctrl.start = accept && last;
	assign lane_ctrl.step  = (state_q == ST_DIV);
	assign lane_ctrl.clear = load;

	dlsd_lane #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_W      (SUM_W),
		.IDX_W      (IDX_W)
	) u_lane_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.sample (left_sample),
		.len    (len),
		.average(avg_left)
	);

	dlsd_lane #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUM_W      (SUM_W),
		.IDX_W      (IDX_W)
	) u_lane_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.sample (right_sample),
		.len    (len),
		.average(avg_right)
	);

	dlsd_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.avg_left      (avg_left),
		.avg_right     (avg_right),
		.threshold     (delta_threshold_q),
		.recal         (recal_interval_q),
		.can_take      (can_take),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.left_average  (left_average),
		.right_average (right_average),
		.left_on_black (left_on_black),
		.right_on_black(right_on_black)
	);

endmodule

// ===== rtl/dlsd_lane.sv =====
module dlsd_lane import dlsd_pkg::*; #(
	parameter int SAMPLE_BITS = 10,
	parameter int SUM_W       = 16,
	parameter int IDX_W       = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lane_ctrl_t             ctrl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [IDX_W-1:0]       len,
	output logic [SAMPLE_BITS-1:0] average
);

	logic [SUM_W-1:0] acc_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W:0]   trial;
	logic             fits;
	logic [IDX_W:0]   diff;

	// one quotient bit per step, dividend shifts out of the top of the sum
	assign trial = {rem_q, acc_q[SUM_W-1]};
	assign fits  = (trial >= {1'b0, len});
	assign diff  = trial - {1'b0, len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= acc_q + SUM_W'(sample);
		end else if (ctrl.step) begin
			acc_q <= {acc_q[SUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
		end else if (ctrl.step) begin
			rem_q <= fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
		end
	end

	assign average = acc_q[SAMPLE_BITS-1:0];

endmodule

// ===== rtl/dlsd_merge.sv =====
module dlsd_merge import dlsd_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [SAMPLE_BITS-1:0] avg_left,
	input  logic [SAMPLE_BITS-1:0] avg_right,
	input  logic [THR_W-1:0]       threshold,
	input  logic [RECAL_W-1:0]     recal,
	output logic                   can_take,
	input  logic                   result_ready,
	output logic                   result_valid,
	output logic [SAMPLE_BITS-1:0] left_average,
	output logic [SAMPLE_BITS-1:0] right_average,
	output logic                   left_on_black,
	output logic                   right_on_black
);

	localparam int CMP_W = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;

	logic                   cal_q;
	logic [RECAL_W-1:0]     win_cnt_q;
	logic [SAMPLE_BITS-1:0] base_left_q;
	logic [SAMPLE_BITS-1:0] base_right_q;
	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] avg_left_q;
	logic [SAMPLE_BITS-1:0] avg_right_q;
	logic                   black_left_q;
	logic                   black_right_q;
	logic [RECAL_W-1:0]     win_next;
	logic                   black_left;
	logic                   black_right;

	assign win_next    = win_cnt_q + 1'b1;
	assign black_left  = CMP_W'(avg_left) > (CMP_W'(base_left_q) + CMP_W'(threshold));
	assign black_right = CMP_W'(avg_right) > (CMP_W'(base_right_q) + CMP_W'(threshold));
	assign can_take    = cal_q || !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q        <= 1'b1;
			win_cnt_q    <= '0;
			base_left_q  <= '0;
			base_right_q <= '0;
			valid_q      <= 1'b0;
		end else begin
			if (load && !cal_q) begin
				valid_q <= 1'b1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				if (cal_q) begin
					base_left_q  <= avg_left;
					base_right_q <= avg_right;
					win_cnt_q    <= '0;
					cal_q        <= 1'b0;
				end else begin
					win_cnt_q <= win_next;
					if (win_next >= recal) begin
						cal_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !cal_q) begin
			avg_left_q    <= avg_left;
			avg_right_q   <= avg_right;
			black_left_q  <= black_left;
			black_right_q <= black_right;
		end
	end

	assign result_valid   = valid_q;
	assign left_average   = avg_left_q;
	assign right_average  = avg_right_q;
	assign left_on_black  = black_left_q;
	assign right_on_black = black_right_q;

endmodule

// ===== rtl/dlsd_checker.sv =====
module dlsd_checker import dlsd_pkg::*; #(
	parameter int SAMPLE_BITS = 10
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   sample_ready,
	input logic                   result_valid,
	input logic                   result_ready,
	input logic [SAMPLE_BITS-1:0] left_average,
	input logic [SAMPLE_BITS-1:0] right_average,
	input logic                   left_on_black,
	input logic                   right_on_black
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable(left_average) && $stable(right_average)
			&& $stable(left_on_black) && $stable(right_on_black))
		else $error("result changed while stalled");

	a_result_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!sample_ready))
		else $error("result appeared without a window end");

	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> sample_ready)
		else $error("sample side not reopened after result");

	a_black_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (left_on_black || right_on_black) |->
			(!left_on_black || left_average != '0)
			&& (!right_on_black || right_average != '0))
		else $error("on-black flag with zero average");

endmodule

bind dual_line_sensor_detector dlsd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dlsd_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
	import dlsd_pkg::*;

	localparam int SAMPLE_W    = 10;
	localparam int MAX_WIN     = 32;
	localparam int DRAIN_WAIT  = 40;
	localparam int LONG_HOLD   = 400;
	localparam int QUIET_LIMIT = 5000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t left_avg;
		sample_t right_avg;
		logic    left_black;
		logic    right_black;
	} window_result_t;

	class detector_board;
		logic [WL_W-1:0]    win_len     = WINDOW_LENGTH_RST;
		logic [THR_W-1:0]   thr         = DELTA_THRESHOLD_RST;
		logic [RECAL_W-1:0] recal       = RECAL_INTERVAL_RST;
		logic [RECAL_W-1:0] since_recal = '0;
		sample_t            base_l      = '0;
		sample_t            base_r      = '0;
		bit                 calibrating = 1'b1;
		int unsigned        sum_l, sum_r, pair_cnt;
		window_result_t     pending[$];
		int                 fails, n_results, n_calib;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WINDOW_LENGTH:   win_len = data[WL_W-1:0];
				REG_DELTA_THRESHOLD: thr = data[THR_W-1:0];
				REG_RECAL_INTERVAL:  recal = data[RECAL_W-1:0];
				default: ;
			endcase
		endfunction

		// running window sums; a closed window either sets the baseline or yields a result
		function void take_pair(sample_t l, sample_t r);
			int unsigned    n;
			sample_t        al, ar;
			window_result_t res;
			n = win_len;
			if (n == 0)
				n = 1;
			if (n > MAX_WIN)
				n = MAX_WIN;
			sum_l += l;
			sum_r += r;
			pair_cnt++;
			if (pair_cnt < n)
				return;
			al = sample_t'(sum_l / n);
			ar = sample_t'(sum_r / n);
			sum_l = 0;
			sum_r = 0;
			pair_cnt = 0;
			if (calibrating) begin
				base_l = al;
				base_r = ar;
				since_recal = '0;
				calibrating = 1'b0;
				n_calib++;
				return;
			end
			res.left_avg    = al;
			res.right_avg   = ar;
			res.left_black  = int'(al) > int'(base_l) + int'(thr);
			res.right_black = int'(ar) > int'(base_r) + int'(thr);
			pending.push_back(res);
			since_recal = since_recal + 1'b1;
			if (since_recal >= recal)
				calibrating = 1'b1;
		endfunction

		function void check_result(sample_t l_avg, sample_t r_avg, logic l_blk, logic r_blk);
			window_result_t want;
			if (pending.size() == 0) begin
				$error("result with no window pending: left_average %0d right_average %0d",
					l_avg, r_avg);
				fails++;
				return;
			end
			want = pending.pop_front();
			n_results++;
			if (l_avg !== want.left_avg) begin
				$error("left_average: expected %0d, actual %0d", want.left_avg, l_avg);
				fails++;
			end
			if (r_avg !== want.right_avg) begin
				$error("right_average: expected %0d, actual %0d", want.right_avg, r_avg);
				fails++;
			end
			if (l_blk !== want.left_black) begin
				$error("left_on_black: expected %0d, actual %0d", want.left_black, l_blk);
				fails++;
			end
			if (r_blk !== want.right_black) begin
				$error("right_on_black: expected %0d, actual %0d", want.right_black, r_blk);
				fails++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;
	logic                  sample_valid;
	logic                  sample_ready;
	sample_t               left_sample;
	sample_t               right_sample;
	logic                  result_valid;
	logic                  result_ready;
	sample_t               left_average;
	sample_t               right_average;
	logic                  left_on_black;
	logic                  right_on_black;

	detector_board board = new;

	int send_idle;
	int recv_stall;
	int hold_gen;
	int hold_seen;
	int hold_left;
	int quiet;
	int n_pairs;
	int n_writes;
	int n_phases;

	dual_line_sensor_detector i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wr_data   (cfg_wr_data),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.left_sample   (left_sample),
		.right_sample  (right_sample),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.left_average  (left_average),
		.right_average (right_average),
		.left_on_black (left_on_black),
		.right_on_black(right_on_black)
	);

	always #1 clk = ~clk;

	// receiver: random stalls, plus a long hold-off when asked for
	always @(negedge clk) begin
		if (hold_seen != hold_gen) begin
			hold_seen = hold_gen;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.check_result(left_average, right_average, left_on_black, right_on_black);
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_pair(sample_t l, sample_t r);
		while ($urandom_range(99) < send_idle) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		do @(posedge clk); while (!sample_ready);
		board.take_pair(l, r);
		n_pairs++;
		@(negedge clk);
	endtask

	// wait for every result, then let a window that closes silently finish
	task automatic settle();
		sample_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		n_writes++;
		@(negedge clk);
	endtask

	// unused upper bits of window length and threshold carry noise; the spare index must be ignored
	task automatic configure(int win, int thr, int recal);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		word[WL_W-1:0] = WL_W'(win);
		write_cfg(REG_WINDOW_LENGTH, word);
		word = CFG_DATA_W'($urandom);
		word[THR_W-1:0] = THR_W'(thr);
		write_cfg(REG_DELTA_THRESHOLD, word);
		word = CFG_DATA_W'(recal);
		write_cfg(REG_RECAL_INTERVAL, word);
		word = CFG_DATA_W'($urandom);
		write_cfg(REG_SPARE, word);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic sample_t gen_sample(int unsigned level);
		int unsigned pick;
		int unsigned v;
		pick = $urandom_range(99);
		if (pick < 60) begin
			v = level + $urandom_range(0, 40);
			if (v > 1023)
				v = 1023;
		end else if (pick < 85) begin
			v = $urandom_range(0, 1023);
		end else begin
			v = ($urandom_range(1) != 0) ? 1023 : 0;
		end
		return sample_t'(v);
	endfunction

	task automatic run_phase(int win, int thr, int recal, int items, int s_idle, int r_stall,
			bit squeeze);
		int unsigned lvl_l;
		int unsigned lvl_r;
		settle();
		configure(win, thr, recal);
		send_idle  = s_idle;
		recv_stall = r_stall;
		if (squeeze)
			hold_gen++;
		lvl_l = $urandom_range(0, 1023);
		lvl_r = $urandom_range(0, 1023);
		repeat (items) begin
			if ($urandom_range(7) == 0)
				lvl_l = $urandom_range(0, 1023);
			if ($urandom_range(7) == 0)
				lvl_r = $urandom_range(0, 1023);
			send_pair(gen_sample(lvl_l), gen_sample(lvl_r));
		end
		n_phases++;
	endtask

	initial begin
		int mode;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_wr_data  = '0;
		sample_valid = 1'b0;
		left_sample  = '0;
		right_sample = '0;
		result_ready = 1'b0;
		send_idle    = 0;
		recv_stall   = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset values: calibration over eight pairs, then one measurement
		repeat (8) send_pair(10'd0, 10'd1023);
		repeat (8) send_pair(10'd1023, 10'd0);

		// single-pair windows, zero threshold, zero recal interval
		settle();
		configure(1, 0, 0);
		send_pair(10'd0, 10'd1023);
		send_pair(10'd1023, 10'd0);
		send_pair(10'd1023, 10'd1023);
		send_pair(10'd512, 10'd511);
		send_pair(10'd513, 10'd510);

		// zero window length, full threshold
		settle();
		configure(0, 1023, 1);
		send_pair(10'd0, 10'd0);
		send_pair(10'd1023, 10'd1023);
		send_pair(10'd1, 10'd1022);
		send_pair(10'd1022, 10'd1);
		n_phases += 3;

		run_phase(4, 20, 3, 150, 0, 0, 1'b0);
		run_phase(63, 0, 1, 70, 70, 0, 1'b0);
		run_phase(3, 1023, 65535, 100, 0, 70, 1'b0);
		run_phase(1, 100, 2, 150, 19, 19, 1'b0);
		run_phase(1, 30, 5, 120, 0, 0, 1'b1);
		run_phase(32, 5, 4, 100, 19, 19, 1'b0);
		run_phase(7, 60, 0, 150, 70, 0, 1'b0);
		repeat (3) begin
			mode = $urandom_range(3);
			run_phase($urandom_range(0, 63), $urandom_range(0, 1023), $urandom_range(0, 8), 60,
				(mode == 1) ? 70 : (mode == 3) ? 19 : 0,
				(mode == 2) ? 70 : (mode == 3) ? 19 : 0, 1'b0);
		end

		settle();
		$display("covered %0d sample requests over %0d phases with %0d register writes",
			n_pairs, n_phases, n_writes);
		$display("checked %0d measurement windows, %0d baseline calibrations",
			board.n_results, board.n_calib);
		if (board.fails == 0 && board.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== dual_line_sensor_detector.f =====
rtl/dlsd_pkg.sv
rtl/dlsd_lane.sv
rtl/dlsd_merge.sv
rtl/dual_line_sensor_detector.sv
rtl/dlsd_checker.sv
test/tb_top.sv
